[design/kwhm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwhm_pkg
// Shared types and constants of the k-way merge priority queue.
// ----------------------------------------------------------------------------
package kwhm_pkg;

  localparam int KEY_W        = 32;
  localparam int RUN_W        = 6;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 2;
  localparam int MAX_RUNS_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_DROP_DUP = 3'd0
  } reg_addr_t;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_REMOVE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [RUN_W-1:0] run_index;
    logic             run_exhausted;
  } in_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]    emitted_key;
    logic                emitted_valid;
    logic [KEY_W-1:0]    top_key;
    logic [RUN_W-1:0]    top_run;
    logic [COUNT_W-1:0]  heap_count;
    logic [STATUS_W-1:0] status;
  } out_rsp_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [RUN_W-1:0] run;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   x;
  } cell_ctl_t;

endpackage

[design/k_way_heap_merge_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_heap_merge_core
// K-way merge priority queue: run heads kept in a sorted row of cells.
// The result is registered: out_valid rises in the cycle after a request is accepted.
// Throughput: 1 request per cycle unless the output is stalled; each cell compares the broadcast key once.
// Reset: count, cell valid bits, last-key tracking and drop_duplicates clear.
// ----------------------------------------------------------------------------
module k_way_heap_merge_core
  import kwhm_pkg::*;
#(
  parameter int MAX_RUNS = MAX_RUNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_rsp_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CNT_W = $clog2(MAX_RUNS + 1);

  logic             drop_dup_r;
  logic             drop_dup_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [KEY_W-1:0] last_key_r;
  logic [KEY_W-1:0] last_key_nxt;
  logic             last_vld_r;
  logic             last_vld_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [KEY_W-1:0] emit_key_r;
  logic [KEY_W-1:0] emit_key_nxt;
  logic             emit_vld_r;
  logic             emit_vld_nxt;
  status_t          status_r;
  status_t          status_nxt;

  logic      accept;
  logic      is_full;
  logic      is_empty;
  cell_ctl_t ctl;
  entry_t    cell_e  [MAX_RUNS];
  logic      cell_lt [MAX_RUNS];
  logic      cfg_wr;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_DROP_DUP) ? {{(DATA_W-1){1'b0}}, drop_dup_r}
                                                  : '0;
  assign drop_dup_nxt = (cfg_wr && cfg_paddr == REG_DROP_DUP) ? cfg_pwdata[0] : drop_dup_r;

  // handshake
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign is_full   = (count_r == CNT_W'(MAX_RUNS));
  assign is_empty  = (count_r == '0);

  always_comb begin
    ctl           = '{op: OP_HOLD, x: '{vld: 1'b1, key: in_data.key, run: in_data.run_index}};
    count_nxt     = count_r;
    last_key_nxt  = last_key_r;
    last_vld_nxt  = last_vld_r;
    emit_key_nxt  = emit_key_r;
    emit_vld_nxt  = emit_vld_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
      emit_key_nxt  = '0;
      emit_vld_nxt  = 1'b0;
      status_nxt    = ST_OK;
      case (in_data.cmd)
        CMD_INSERT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op    = OP_INSERT;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_ADVANCE: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            emit_key_nxt = cell_e[0].key;
            emit_vld_nxt = !(drop_dup_r && last_vld_r && last_key_r == cell_e[0].key);
            last_key_nxt = cell_e[0].key;
            last_vld_nxt = 1'b1;
            if (in_data.run_exhausted) begin
              ctl.op    = OP_REMOVE;
              count_nxt = count_r - 1'b1;
            end else begin
              ctl.op    = OP_REPLACE;
              ctl.x.run = cell_e[0].run;
            end
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // cell row, head at index 0
  for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
    entry_t left_e;
    logic   left_lt;
    logic   keep_lt;
    entry_t right_e;
    logic   right_lt;

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_lt = 1'b0;
      assign keep_lt = 1'b0;
    end else begin : g_body
      assign left_e  = cell_e[i-1];
      assign left_lt = cell_lt[i-1];
      assign keep_lt = cell_lt[i];
    end

    if (i == MAX_RUNS - 1) begin : g_tail
      assign right_e  = '0;
      assign right_lt = 1'b1;
    end else begin : g_inner
      assign right_e  = cell_e[i+1];
      assign right_lt = cell_lt[i+1];
    end

    kwhm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .left_e   (left_e),
      .left_lt  (left_lt),
      .keep_lt  (keep_lt),
      .right_e  (right_e),
      .right_lt (right_lt),
      .ent      (cell_e[i]),
      .lt       (cell_lt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_dup_r  <= 1'b0;
      count_r     <= '0;
      last_key_r  <= '0;
      last_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drop_dup_r  <= drop_dup_nxt;
      count_r     <= count_nxt;
      last_key_r  <= last_key_nxt;
      last_vld_r  <= last_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_key_r <= emit_key_nxt;
    emit_vld_r <= emit_vld_nxt;
    status_r   <= status_nxt;
  end

  // top fields follow the cell row, which only moves on an accepted request
  assign out_data.emitted_key   = emit_key_r;
  assign out_data.emitted_valid = emit_vld_r;
  assign out_data.top_key       = cell_e[0].vld ? cell_e[0].key : '0;
  assign out_data.top_run       = cell_e[0].vld ? cell_e[0].run : '0;
  assign out_data.heap_count    = COUNT_W'(count_r);
  assign out_data.status        = status_r;

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RUNS))
    else $error("entry count above capacity");

  a_head_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
    cell_e[0].vld == (count_r != '0))
    else $error("head cell valid disagrees with entry count");

  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.cmd == CMD_INSERT && !is_full |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the entry count");

  a_status_empty : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.cmd == CMD_ADVANCE && is_empty |=> status_r == ST_EMPTY && !emit_vld_r)
    else $error("advance on empty queue not flagged");
`endif

endmodule

[design/kwhm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwhm_cell
// One slot of the sorted entry row: compares the broadcast entry with its own
// and takes its own, its neighbor's or the new entry.
// ----------------------------------------------------------------------------
module kwhm_cell
  import kwhm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    left_e,
  input  logic      left_lt,
  input  logic      keep_lt,
  input  entry_t    right_e,
  input  logic      right_lt,
  output entry_t    ent,
  output logic      lt
);

  logic             vld_r;
  logic             vld_nxt;
  logic [KEY_W-1:0] key_r;
  logic [RUN_W-1:0] run_r;
  entry_t           ent_nxt;

  assign ent = '{vld: vld_r, key: key_r, run: run_r};

  // broadcast entry orders before this slot; an empty slot is above all
  assign lt = !vld_r || (ctl.x.key < key_r) ||
              ((ctl.x.key == key_r) && (ctl.x.run < run_r));

  always_comb begin
    ent_nxt = ent;
    case (ctl.op)
      OP_INSERT: begin
        if (lt) begin
          ent_nxt = left_lt ? left_e : ctl.x;
        end
      end
      OP_REPLACE: begin
        if (keep_lt) begin
          ent_nxt = ent;
        end else if (right_lt) begin
          ent_nxt = ctl.x;
        end else begin
          ent_nxt = right_e;
        end
      end
      OP_REMOVE: begin
        ent_nxt = right_e;
      end
      default: begin
        ent_nxt = ent;
      end
    endcase
  end

  assign vld_nxt = ent_nxt.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= ent_nxt.key;
    run_r <= ent_nxt.run;
  end

endmodule
